/* hw/rtl/mcrp_pkg.sv */
// Shared types, codes and constants of the MQTT client receive parser.
`timescale 1ns / 1ps
`default_nettype none

package mcrp_pkg;

  localparam int MAX_LENGTH_BYTES = 4;
  localparam int FIFO_DEPTH       = 4;

  localparam logic [3:0] EV_TOPIC     = 4'd0;
  localparam logic [3:0] EV_PAYLOAD   = 4'd1;
  localparam logic [3:0] EV_PUB_DONE  = 4'd2;
  localparam logic [3:0] EV_SEND_ACK  = 4'd3;
  localparam logic [3:0] EV_CONNECTED = 4'd4;
  localparam logic [3:0] EV_REFUSED   = 4'd5;
  localparam logic [3:0] EV_KEEPALIVE = 4'd6;
  localparam logic [3:0] EV_UNKNOWN   = 4'd7;
  localparam logic [3:0] EV_PARSE_ERR = 4'd8;
  localparam logic [3:0] EV_LEN_ERR   = 4'd9;

  localparam logic [3:0] T_CONNACK  = 4'd2;
  localparam logic [3:0] T_PUBLISH  = 4'd3;
  localparam logic [3:0] T_PUBACK   = 4'd4;
  localparam logic [3:0] T_PUBREL   = 4'd6;
  localparam logic [3:0] T_PUBCOMP  = 4'd7;
  localparam logic [3:0] T_SUBACK   = 4'd9;
  localparam logic [3:0] T_UNSUBACK = 4'd11;
  localparam logic [3:0] T_PINGRESP = 4'd13;

  localparam logic [3:0] ACK_PUBACK  = 4'd4;
  localparam logic [3:0] ACK_PUBREC  = 4'd5;
  localparam logic [3:0] ACK_PUBCOMP = 4'd7;

  typedef struct packed {
    logic [3:0]  ev;
    logic [7:0]  data;
    logic [3:0]  ptype;
    logic [3:0]  flags;
    logic [15:0] mid;
    logic [3:0]  ack;
    logic        last;
  } result_t;

  // Up to two results per byte, in order.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t e0;
    result_t e1;
  } push_t;

  function automatic result_t mk_result(logic [3:0] ev, logic [7:0] data,
                                        logic [3:0] ptype, logic [3:0] flags,
                                        logic [15:0] mid, logic [3:0] ack,
                                        logic last);
    result_t r;
    r.ev    = ev;
    r.data  = data;
    r.ptype = ptype;
    r.flags = flags;
    r.mid   = mid;
    r.ack   = ack;
    r.last  = last;
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mqtt_client_rx_parser.sv */
// MQTT client receive parser: top level with the packet state and result queue.
//
// Input channel (in_valid/in_ready): one received byte per transfer, with
// restart. restart=1 drops any partial packet and returns the parser to its
// reset state; that byte gives no result.
// Output channel (out_valid/out_ready): one result per transfer (event_res,
// data_byte, packet_type, packet_flags, message_id, ack_type, last).
// Each byte updates the parser state in the cycle it is taken and places
// zero, one or two results in a four-entry queue; the first result enters
// the queue in the cycle after the byte transfer.
// Throughput: one byte per cycle while the queue holds at most two results;
// in_ready drops when fewer than two entries are free, so a stalled receiver
// holds back the byte stream after at most four queued results.
// An overlong remaining length reports a length error and the parser then
// ignores every byte until restart.
// rst clears the parser state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module mqtt_client_rx_parser #(
  parameter int MAX_LENGTH_BYTES = mcrp_pkg::MAX_LENGTH_BYTES
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  rx_byte,
  input  wire         restart,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [3:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [3:0]  packet_type,
  output logic [3:0]  packet_flags,
  output logic [15:0] message_id,
  output logic [3:0]  ack_type,
  output logic        last
);

  localparam int LEN_W = 7 * MAX_LENGTH_BYTES;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEN, PH_BODY, PH_TLEN, PH_TOPIC, PH_MID, PH_PAYLOAD, PH_HALT
  } phase_t;

  phase_t            phase, phase_next;
  logic [3:0]        cur_type, cur_type_next;
  logic [3:0]        cur_flags, cur_flags_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [2:0]        len_count, len_count_next;
  logic [15:0]       topic_left, topic_left_next;
  logic [15:0]       held_id, held_id_next;
  logic [1:0]        body_index, body_index_next;
  logic [7:0]        return_code, return_code_next;

  logic              in_fire;
  logic              body_step;
  logic              do_finish;
  logic              r0_valid, r1_valid;
  mcrp_pkg::result_t r0, r1;
  phase_t            after_topic;
  mcrp_pkg::push_t   push;
  mcrp_pkg::result_t head;
  logic              room;

  assign in_fire     = in_valid && in_ready;
  assign in_ready    = room;
  assign after_topic = (cur_flags[2:1] != 2'b00) ? PH_MID : PH_PAYLOAD;

  always_comb begin
    phase_next       = phase;
    cur_type_next    = cur_type;
    cur_flags_next   = cur_flags;
    bytes_left_next  = bytes_left;
    len_count_next   = len_count;
    topic_left_next  = topic_left;
    held_id_next     = held_id;
    body_index_next  = body_index;
    return_code_next = return_code;
    body_step        = 1'b0;
    do_finish        = 1'b0;
    r0_valid         = 1'b0;
    r1_valid         = 1'b0;
    r0               = '0;
    r1               = '0;

    if (in_fire) begin
      if (restart) begin
        phase_next       = PH_IDLE;
        cur_type_next    = '0;
        cur_flags_next   = '0;
        bytes_left_next  = '0;
        len_count_next   = '0;
        topic_left_next  = '0;
        held_id_next     = '0;
        body_index_next  = '0;
        return_code_next = '0;
      end else begin
        case (phase)
          PH_IDLE: begin
            cur_type_next    = rx_byte[7:4];
            cur_flags_next   = rx_byte[3:0];
            bytes_left_next  = '0;
            len_count_next   = '0;
            topic_left_next  = '0;
            held_id_next     = '0;
            body_index_next  = '0;
            return_code_next = '0;
            phase_next       = PH_LEN;
          end
          PH_LEN: begin
            for (int i = 0; i < MAX_LENGTH_BYTES; i++) begin
              if (len_count == 3'(i)) begin
                bytes_left_next[7*i +: 7] = bytes_left[7*i +: 7] | rx_byte[6:0];
              end
            end
            len_count_next = len_count + 3'd1;
            if (rx_byte[7]) begin
              if (len_count_next >= 3'(MAX_LENGTH_BYTES)) begin
                phase_next = PH_HALT;
                r0_valid   = 1'b1;
                r0 = mcrp_pkg::mk_result(mcrp_pkg::EV_LEN_ERR, 8'd0, cur_type,
                                         cur_flags, 16'd0, 4'd0, 1'b1);
              end
            end else begin
              phase_next = (cur_type == mcrp_pkg::T_PUBLISH) ? PH_TLEN : PH_BODY;
              if (bytes_left_next == '0) begin
                do_finish = 1'b1;
              end
            end
          end
          PH_BODY: begin
            body_step = 1'b1;
            if (body_index < 2'd2) begin
              if (cur_type == mcrp_pkg::T_CONNACK && body_index == 2'd1) begin
                return_code_next = rx_byte;
              end
              if (cur_type == mcrp_pkg::T_PUBREL) begin
                held_id_next = {held_id[7:0], rx_byte};
              end
              body_index_next = body_index + 2'd1;
            end
          end
          PH_TLEN: begin
            body_step       = 1'b1;
            topic_left_next = {topic_left[7:0], rx_byte};
            body_index_next = body_index + 2'd1;
            if (body_index_next >= 2'd2) begin
              body_index_next = '0;
              phase_next = (topic_left_next != '0) ? PH_TOPIC : after_topic;
            end
          end
          PH_TOPIC: begin
            body_step       = 1'b1;
            r0_valid        = 1'b1;
            r0 = mcrp_pkg::mk_result(mcrp_pkg::EV_TOPIC, rx_byte, cur_type,
                                     cur_flags, 16'd0, 4'd0, 1'b0);
            topic_left_next = topic_left - 16'd1;
            if (topic_left_next == '0) begin
              phase_next = after_topic;
            end
          end
          PH_MID: begin
            body_step       = 1'b1;
            held_id_next    = {held_id[7:0], rx_byte};
            body_index_next = body_index + 2'd1;
            if (body_index_next >= 2'd2) begin
              r0_valid   = 1'b1;
              r0 = mcrp_pkg::mk_result(mcrp_pkg::EV_SEND_ACK, 8'd0, cur_type,
                                       cur_flags, held_id_next,
                                       cur_flags[1] ? mcrp_pkg::ACK_PUBACK
                                                    : mcrp_pkg::ACK_PUBREC,
                                       1'b0);
              phase_next = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            body_step = 1'b1;
            r0_valid  = 1'b1;
            r0 = mcrp_pkg::mk_result(mcrp_pkg::EV_PAYLOAD, rx_byte, cur_type,
                                     cur_flags, 16'd0, 4'd0, 1'b0);
          end
          default: ;
        endcase

        if (body_step) begin
          if (bytes_left != '0) begin
            bytes_left_next = bytes_left - LEN_W'(1);
          end
          if (bytes_left_next == '0) begin
            do_finish = 1'b1;
          end
        end

        // End of packet: report by type, judged on the updated body state.
        if (do_finish) begin
          r1_valid = 1'b1;
          case (cur_type)
            mcrp_pkg::T_CONNACK: begin
              if (body_index_next < 2'd2) begin
                r1.ev = mcrp_pkg::EV_PARSE_ERR;
              end else if (return_code_next == 8'd0) begin
                r1.ev = mcrp_pkg::EV_CONNECTED;
              end else begin
                r1.ev   = mcrp_pkg::EV_REFUSED;
                r1.data = return_code_next;
              end
            end
            mcrp_pkg::T_PUBLISH: begin
              if (phase_next != PH_PAYLOAD) begin
                r1.ev = mcrp_pkg::EV_PARSE_ERR;
              end else begin
                r1.ev  = mcrp_pkg::EV_PUB_DONE;
                r1.mid = held_id_next;
              end
            end
            mcrp_pkg::T_PUBREL: begin
              if (body_index_next < 2'd2) begin
                r1.ev = mcrp_pkg::EV_PARSE_ERR;
              end else begin
                r1.ev  = mcrp_pkg::EV_SEND_ACK;
                r1.mid = held_id_next;
                r1.ack = mcrp_pkg::ACK_PUBCOMP;
              end
            end
            mcrp_pkg::T_PINGRESP: r1.ev = mcrp_pkg::EV_KEEPALIVE;
            mcrp_pkg::T_PUBACK, mcrp_pkg::T_PUBCOMP,
            mcrp_pkg::T_SUBACK, mcrp_pkg::T_UNSUBACK: r1_valid = 1'b0;
            default: r1.ev = mcrp_pkg::EV_UNKNOWN;
          endcase
          r1.ptype   = cur_type;
          r1.flags   = cur_flags;
          r1.last    = 1'b1;
          phase_next = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      cur_type    <= '0;
      cur_flags   <= '0;
      bytes_left  <= '0;
      len_count   <= '0;
      topic_left  <= '0;
      held_id     <= '0;
      body_index  <= '0;
      return_code <= '0;
    end else begin
      phase       <= phase_next;
      cur_type    <= cur_type_next;
      cur_flags   <= cur_flags_next;
      bytes_left  <= bytes_left_next;
      len_count   <= len_count_next;
      topic_left  <= topic_left_next;
      held_id     <= held_id_next;
      body_index  <= body_index_next;
      return_code <= return_code_next;
    end
  end

  always_comb begin
    push.v0 = r0_valid || r1_valid;
    push.v1 = r0_valid && r1_valid;
    push.e0 = r0_valid ? r0 : r1;
    push.e1 = r1;
  end

  mcrp_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign event_res    = head.ev;
  assign data_byte    = head.data;
  assign packet_type  = head.ptype;
  assign packet_flags = head.flags;
  assign message_id   = head.mid;
  assign ack_type     = head.ack;
  assign last         = head.last;

endmodule

`default_nettype wire

/* hw/rtl/mcrp_result_fifo.sv */
// Small result queue: takes up to two results per cycle, gives one per transfer.
`timescale 1ns / 1ps
`default_nettype none

module mcrp_result_fifo (
  input  wire                    clk,
  input  wire                    rst,
  input  mcrp_pkg::push_t        push,
  output logic                   room,
  output logic                   out_valid,
  input  wire                    out_ready,
  output mcrp_pkg::result_t      head
);

  // Depth must be a power of two.
  localparam int DEPTH = mcrp_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mcrp_pkg::result_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pop;

  assign out_valid = (count != '0);
  assign head      = entries[rd_ptr];
  assign room      = (count <= CNT_W'(DEPTH - 2));
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_next = count + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push.v0 && push.v1) begin
        wr_ptr <= wr_ptr + PTR_W'(2);
      end else if (push.v0) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      entries[wr_ptr] <= push.e0;
    end
    if (push.v1) begin
      entries[wr_ptr + PTR_W'(1)] <= push.e1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mcrp_checker.sv */
// Port-level checks of the MQTT client receive parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mcrp_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_ready,
  input wire [3:0]  event_res,
  input wire [7:0]  data_byte,
  input wire [3:0]  ack_type,
  input wire        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(data_byte))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_stream_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == mcrp_pkg::EV_TOPIC || event_res == mcrp_pkg::EV_PAYLOAD)
      |-> !last)
    else $error("streamed byte marked last");

  a_ack_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == mcrp_pkg::EV_SEND_ACK
      |-> ack_type == mcrp_pkg::ACK_PUBACK || ack_type == mcrp_pkg::ACK_PUBREC
          || ack_type == mcrp_pkg::ACK_PUBCOMP)
    else $error("ack request without a valid ack type");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != mcrp_pkg::EV_TOPIC && event_res != mcrp_pkg::EV_PAYLOAD
      && event_res != mcrp_pkg::EV_REFUSED |-> data_byte == 8'd0)
    else $error("data byte set on an event that carries none");

endmodule

bind mqtt_client_rx_parser mcrp_checker u_mcrp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .event_res (event_res),
  .data_byte (data_byte),
  .ack_type  (ack_type),
  .last      (last)
);

`default_nettype wire

/* tb/tb_mqtt_client_rx_parser.sv */
// Self-checking testbench for the MQTT client receive parser: packet stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb_mqtt_client_rx_parser;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEN, ST_BODY, ST_TOPIC_LEN, ST_TOPIC, ST_MSG_ID, ST_PAYLOAD, ST_HALT
  } rx_phase_e;

  class mqtt_event_tracker;
    mcrp_pkg::result_t expected_events[$];
    int          errors;
    rx_phase_e   phase;
    logic [3:0]  cur_type;
    logic [3:0]  cur_flags;
    logic [27:0] bytes_left;
    logic [2:0]  len_count;
    logic [15:0] topic_left;
    logic [15:0] held_id;
    logic [1:0]  body_idx;
    logic [7:0]  ret_code;
    logic        connected;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = ST_IDLE;
      cur_type = '0;
      cur_flags = '0;
      bytes_left = '0;
      len_count = '0;
      topic_left = '0;
      held_id = '0;
      body_idx = '0;
      ret_code = '0;
      connected = 1'b0;
    endfunction

    function void emit(logic [3:0] ev, logic [7:0] data, logic [15:0] mid,
                       logic [3:0] ack, logic lst);
      mcrp_pkg::result_t r;
      r.ev = ev;
      r.data = data;
      r.ptype = cur_type;
      r.flags = cur_flags;
      r.mid = mid;
      r.ack = ack;
      r.last = lst;
      expected_events.push_back(r);
    endfunction

    function rx_phase_e after_topic();
      return (cur_flags[2:1] != 2'b00) ? ST_MSG_ID : ST_PAYLOAD;
    endfunction

    function void close_packet();
      rx_phase_e ph;
      ph = phase;
      phase = ST_IDLE;
      case (cur_type)
        mcrp_pkg::T_CONNACK: begin
          if (body_idx < 2) begin
            emit(mcrp_pkg::EV_PARSE_ERR, 8'h00, 16'h0000, 4'h0, 1'b1);
          end else if (ret_code == 8'h00) begin
            connected = 1'b1;
            emit(mcrp_pkg::EV_CONNECTED, 8'h00, 16'h0000, 4'h0, 1'b1);
          end else begin
            connected = 1'b0;
            emit(mcrp_pkg::EV_REFUSED, ret_code, 16'h0000, 4'h0, 1'b1);
          end
        end
        mcrp_pkg::T_PUBLISH: begin
          if (ph != ST_PAYLOAD) emit(mcrp_pkg::EV_PARSE_ERR, 8'h00, 16'h0000, 4'h0, 1'b1);
          else emit(mcrp_pkg::EV_PUB_DONE, 8'h00, held_id, 4'h0, 1'b1);
        end
        mcrp_pkg::T_PUBREL: begin
          if (body_idx < 2) emit(mcrp_pkg::EV_PARSE_ERR, 8'h00, 16'h0000, 4'h0, 1'b1);
          else emit(mcrp_pkg::EV_SEND_ACK, 8'h00, held_id, mcrp_pkg::ACK_PUBCOMP, 1'b1);
        end
        mcrp_pkg::T_PINGRESP: emit(mcrp_pkg::EV_KEEPALIVE, 8'h00, 16'h0000, 4'h0, 1'b1);
        mcrp_pkg::T_PUBACK, mcrp_pkg::T_PUBCOMP,
        mcrp_pkg::T_SUBACK, mcrp_pkg::T_UNSUBACK: ;
        default: emit(mcrp_pkg::EV_UNKNOWN, 8'h00, 16'h0000, 4'h0, 1'b1);
      endcase
    endfunction

    // Called on every input transfer; queues the results this byte must produce.
    function void take_byte(logic [7:0] b, logic rs);
      if (rs) begin
        clear();
        return;
      end
      case (phase)
        ST_IDLE: begin
          cur_type = b[7:4];
          cur_flags = b[3:0];
          bytes_left = '0;
          len_count = '0;
          topic_left = '0;
          held_id = '0;
          body_idx = '0;
          ret_code = '0;
          phase = ST_LEN;
          return;
        end
        ST_LEN: begin
          if (len_count < 4) bytes_left = bytes_left | (28'(b[6:0]) << (7 * len_count));
          len_count = len_count + 3'd1;
          if (b[7]) begin
            if (len_count >= mcrp_pkg::MAX_LENGTH_BYTES) begin
              phase = ST_HALT;
              emit(mcrp_pkg::EV_LEN_ERR, 8'h00, 16'h0000, 4'h0, 1'b1);
            end
            return;
          end
          phase = (cur_type == mcrp_pkg::T_PUBLISH) ? ST_TOPIC_LEN : ST_BODY;
          if (bytes_left == 0) close_packet();
          return;
        end
        ST_BODY: begin
          if (body_idx < 2) begin
            if (cur_type == mcrp_pkg::T_CONNACK && body_idx == 1) ret_code = b;
            if (cur_type == mcrp_pkg::T_PUBREL) held_id = {held_id[7:0], b};
            body_idx = body_idx + 2'd1;
          end
        end
        ST_TOPIC_LEN: begin
          topic_left = {topic_left[7:0], b};
          body_idx = body_idx + 2'd1;
          if (body_idx >= 2) begin
            body_idx = '0;
            phase = (topic_left != 0) ? ST_TOPIC : after_topic();
          end
        end
        ST_TOPIC: begin
          emit(mcrp_pkg::EV_TOPIC, b, 16'h0000, 4'h0, 1'b0);
          topic_left = topic_left - 16'd1;
          if (topic_left == 0) phase = after_topic();
        end
        ST_MSG_ID: begin
          held_id = {held_id[7:0], b};
          body_idx = body_idx + 2'd1;
          if (body_idx >= 2) begin
            emit(mcrp_pkg::EV_SEND_ACK, 8'h00, held_id,
                 cur_flags[1] ? mcrp_pkg::ACK_PUBACK : mcrp_pkg::ACK_PUBREC, 1'b0);
            phase = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: emit(mcrp_pkg::EV_PAYLOAD, b, 16'h0000, 4'h0, 1'b0);
        default: return;
      endcase
      if (bytes_left != 0) bytes_left = bytes_left - 28'd1;
      if (bytes_left == 0) close_packet();
    endfunction

    function void diff_field(string name, logic [15:0] e, logic [15:0] a, logic [3:0] ev);
      if (a !== e) begin
        errors++;
        $display("%0t ns: %s mismatch on event %0d, expected %0h, actual %0h",
                 $time, name, ev, e, a);
      end
    endfunction

    function void check_event(mcrp_pkg::result_t got);
      mcrp_pkg::result_t exp;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual ev=%0d data=%02h mid=%04h",
                 $time, got.ev, got.data, got.mid);
        return;
      end
      exp = expected_events.pop_front();
      diff_field("event_res", 16'(exp.ev), 16'(got.ev), exp.ev);
      diff_field("data_byte", 16'(exp.data), 16'(got.data), exp.ev);
      diff_field("packet_type", 16'(exp.ptype), 16'(got.ptype), exp.ev);
      diff_field("packet_flags", 16'(exp.flags), 16'(got.flags), exp.ev);
      diff_field("message_id", exp.mid, got.mid, exp.ev);
      diff_field("ack_type", 16'(exp.ack), 16'(got.ack), exp.ev);
      diff_field("last", 16'(exp.last), 16'(got.last), exp.ev);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        restart;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  event_res;
  logic [7:0]  data_byte;
  logic [3:0]  packet_type;
  logic [3:0]  packet_flags;
  logic [15:0] message_id;
  logic [3:0]  ack_type;
  logic        last;

  mqtt_client_rx_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte), .restart(restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .data_byte(data_byte), .packet_type(packet_type),
    .packet_flags(packet_flags), .message_id(message_id), .ack_type(ack_type), .last(last)
  );

  mqtt_event_tracker tracker = new();
  logic [7:0] pkt[$];
  int bytes_fed = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;

  always #6 clk = ~clk;

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver back-pressure: switches among several stall patterns
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (stall_phase % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    mcrp_pkg::result_t got;
    if (!rst && out_valid && out_ready) begin
      got.ev = event_res;
      got.data = data_byte;
      got.ptype = packet_type;
      got.flags = packet_flags;
      got.mid = message_id;
      got.ack = ack_type;
      got.last = last;
      tracker.check_event(got);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic rs, input bit counted);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      rx_byte <= 8'($urandom);
      restart <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte <= b;
    restart <= rs;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(b, rs);
    if (counted) bytes_fed++;
  endtask

  task automatic send_restart();
    send_byte(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], 1'b0, 1'b1);
    pkt.delete();
  endtask

  // remaining length, optionally padded with redundant continuation bytes
  task automatic add_len(input int n, input int pad);
    int nb;
    logic [7:0] v;
    nb = 1;
    while (nb < 4 && (n >> (7 * nb)) != 0) nb++;
    nb = nb + pad;
    if (nb > 4) nb = 4;
    for (int i = 0; i < nb; i++) begin
      v = 8'((n >> (7 * i)) & 127);
      if (i < nb - 1) v[7] = 1'b1;
      pkt.push_back(v);
    end
  endtask

  function automatic int pick_pad();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic int pick_rem();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 2;
    if (r == 6) return 0;
    if (r == 7) return 1;
    return $urandom_range(3, 6);
  endfunction

  task automatic build_packet(input logic [3:0] t, input logic [3:0] f, input int rem,
                              input logic [7:0] code);
    pkt.push_back({t, f});
    add_len(rem, pick_pad());
    for (int i = 0; i < rem; i++) pkt.push_back((i == 1) ? code : 8'($urandom));
  endtask

  task automatic build_publish();
    logic [3:0]  f;
    logic [15:0] tlen;
    logic [15:0] mid;
    logic [7:0]  body[$];
    int tl, pl, qos, rem;
    f = 4'($urandom);
    qos = (f[2:1] != 2'b00) ? 2 : 0;
    tl = $urandom_range(0, 6);
    pl = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 12);
    rem = 2 + tl + qos + pl;
    tlen = 16'(tl);
    if ($urandom_range(0, 7) == 0) begin
      rem = $urandom_range(0, 2 + tl + qos - 1);
      if ($urandom_range(0, 1)) tlen = 16'($urandom);
    end
    case ($urandom_range(0, 5))
      0: mid = 16'h0000;
      1: mid = 16'hFFFF;
      default: mid = 16'($urandom);
    endcase
    body.push_back(tlen[15:8]);
    body.push_back(tlen[7:0]);
    repeat (tl) body.push_back(8'($urandom));
    if (qos != 0) begin
      body.push_back(mid[15:8]);
      body.push_back(mid[7:0]);
    end
    repeat (pl) body.push_back(8'($urandom));
    pkt.push_back({mcrp_pkg::T_PUBLISH, f});
    add_len(rem, pick_pad());
    for (int i = 0; i < rem; i++) pkt.push_back(body[i]);
  endtask

  task automatic build_any();
    int sel;
    logic [3:0] t;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      build_publish();
    end else if (sel < 60) begin
      build_packet(mcrp_pkg::T_CONNACK, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0,
                   pick_rem(), $urandom_range(0, 1) ? 8'h00 : 8'($urandom));
    end else if (sel < 75) begin
      build_packet(mcrp_pkg::T_PUBREL, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h2,
                   pick_rem(), 8'($urandom));
    end else if (sel < 83) begin
      build_packet(mcrp_pkg::T_PINGRESP, 4'h0,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 8'($urandom));
    end else if (sel < 91) begin
      case ($urandom_range(0, 3))
        0: t = mcrp_pkg::T_PUBACK;
        1: t = mcrp_pkg::T_PUBCOMP;
        2: t = mcrp_pkg::T_SUBACK;
        default: t = mcrp_pkg::T_UNSUBACK;
      endcase
      build_packet(t, 4'($urandom), pick_rem(), 8'($urandom));
    end else begin
      do t = 4'($urandom);
      while (t == mcrp_pkg::T_CONNACK || t == mcrp_pkg::T_PUBLISH ||
             t == mcrp_pkg::T_PUBACK || t == mcrp_pkg::T_PUBREL ||
             t == mcrp_pkg::T_PUBCOMP || t == mcrp_pkg::T_SUBACK ||
             t == mcrp_pkg::T_UNSUBACK || t == mcrp_pkg::T_PINGRESP);
      build_packet(t, 4'($urandom), $urandom_range(0, 5), 8'($urandom));
    end
  endtask

  initial begin
    int sel, keep, wait_cycles;
    logic [7:0] directed[$];
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    restart = 1'b0;
    out_ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // accepted CONNACK, QoS publish with both QoS bits, PUBREL, PINGRESP,
    // unknown type 15, short CONNACK, overlong remaining length
    directed = '{8'h20, 8'h02, 8'h00, 8'h00,
                 8'h3E, 8'h05, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                 8'h62, 8'h02, 8'h00, 8'h01,
                 8'hD0, 8'h00,
                 8'hF0, 8'h00,
                 8'h20, 8'h01, 8'h00,
                 8'h00, 8'h80, 8'h80, 8'h80, 8'h80};
    foreach (directed[i]) send_byte(directed[i], 1'b0, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_restart();

    while (bytes_fed < 1100) begin
      sel = $urandom_range(0, 99);
      if (sel < 86) begin
        build_any();
        send_packet();
      end else if (sel < 90) begin
        // connection reset in the middle of a packet
        build_any();
        if (pkt.size() > 1) begin
          keep = $urandom_range(1, pkt.size() - 1);
          while (pkt.size() > keep) void'(pkt.pop_back());
        end
        send_packet();
        send_restart();
      end else if (sel < 93) begin
        // overlong length, then halted until restart
        pkt.push_back(8'($urandom));
        repeat (4) pkt.push_back(8'($urandom) | 8'h80);
        send_packet();
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
        send_restart();
      end else if (sel < 95) begin
        // four-byte length with the top bits set; cut short by a restart
        pkt.push_back(8'($urandom));
        repeat (3) pkt.push_back(8'($urandom) | 8'h80);
        pkt.push_back(8'($urandom_range(64, 127)));
        repeat ($urandom_range(0, 5)) pkt.push_back(8'($urandom));
        send_packet();
        send_restart();
      end else if (sel < 98) begin
        repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
        send_packet();
        send_restart();
      end else begin
        send_restart();
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    wait_cycles = 0;
    while (tracker.expected_events.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (tracker.expected_events.size() != 0) begin
      tracker.errors++;
      $display("%0t ns: %0d expected results never arrived, first expected ev=%0d",
               $time, tracker.expected_events.size(), tracker.expected_events[0].ev);
    end
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
